[rtl/pta_pkg.sv]
// shared types and constants for the priority task table
`timescale 1ns / 1ps
package pta_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_EDIT   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EXEC   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] task_id;
    logic [15:0] user_id;
    logic [31:0] prio;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clr_we;
    logic rd_en;
    logic cmd_load;
    logic commit;
    logic res_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

[rtl/priority_task_table.sv]
// priority task table top level: controller plus datapath
//
//  channel  dir  handshake               payload
//  request  in   in_valid_i / in_ready_o   cmd_i, user_id_i, task_id_i, priority_req_i
//  result   out  out_valid_o / out_ready_i status_o, user_id_out_o
//
// each request is taken in idle, then the whole table is scanned with one memory
// read per entry, followed by drain, commit and hand-off of the result. the next
// request is taken only once the result is loaded. after reset a clearing pass
// empties every entry; no request is taken meanwhile. a new request is taken while
// the previous result waits; its result is held back until the output register is
// free.
`timescale 1ns / 1ps
module priority_task_table import pta_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] user_id_i,
  input  logic [15:0] task_id_i,
  input  logic [31:0] priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] user_id_out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  ctrl_t         ctrl;
  stat_t         stat;
  logic [AW-1:0] addr;

  pta_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl),
    .addr_o     (addr),
    .stat_i     (stat)
  );

  pta_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .addr_i         (addr),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .user_id_i      (user_id_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .user_id_out_o  (user_id_out_o)
  );

  // one request at a time in the scan loop
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while previous one still busy");

  // only an executed top task returns a user
  a_user_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (user_id_out_o == 16'd0))
    else $error("user returned on failed request");

  // results are loaded only at the end of a request
  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result produced while idle");

endmodule

[rtl/pta_datapath.sv]
// entry memory, scan accumulators, commit write and result register
`timescale 1ns / 1ps
module pta_datapath import pta_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ctrl_t         ctrl_i,
  input  logic [AW-1:0] addr_i,
  output stat_t         stat_o,
  input  logic [1:0]    cmd_i,
  input  logic [15:0]   user_id_i,
  input  logic [15:0]   task_id_i,
  input  logic [31:0]   priority_req_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [1:0]    status_o,
  output logic [15:0]   user_id_out_o
);

  entry_t mem [CAPACITY];

  entry_t        rdata_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;

  cmd_e        cmd_q;
  logic [15:0] task_q;
  logic [15:0] user_q;
  logic [31:0] pri_q;

  logic          match_found_q, match_found_d;
  logic [AW-1:0] match_idx_q, match_idx_d;
  logic [15:0]   match_user_q, match_user_d;
  logic          free_found_q, free_found_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic          best_found_q, best_found_d;
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic [31:0]   best_prio_q, best_prio_d;
  logic [15:0]   best_task_q, best_task_d;
  logic [15:0]   best_user_q, best_user_d;

  logic          out_valid_q;
  status_e       status_q;
  logic [15:0]   user_out_q;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  status_e       res_status;
  logic [15:0]   res_user;

  // memory: one write port shared by clearing pass and commit, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
    rd_idx_q <= addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd_load) begin
      cmd_q  <= cmd_e'(cmd_i);
      task_q <= task_id_i;
      user_q <= user_id_i;
      pri_q  <= priority_req_i;
    end
  end

  // scan step over one entry per cycle
  always_comb begin
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    match_user_d  = match_user_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    best_found_d  = best_found_q;
    best_idx_d    = best_idx_q;
    best_prio_d   = best_prio_q;
    best_task_d   = best_task_q;
    best_user_d   = best_user_q;
    if (ctrl_i.cmd_load) begin
      match_found_d = 1'b0;
      free_found_d  = 1'b0;
      best_found_d  = 1'b0;
    end else if (rd_vld_q) begin
      if (rdata_q.valid && rdata_q.task_id == task_q && !match_found_q) begin
        match_found_d = 1'b1;
        match_idx_d   = rd_idx_q;
        match_user_d  = rdata_q.user_id;
      end
      if (!rdata_q.valid && !free_found_q) begin
        free_found_d = 1'b1;
        free_idx_d   = rd_idx_q;
      end
      if (rdata_q.valid && (!best_found_q || rdata_q.prio > best_prio_q ||
          (rdata_q.prio == best_prio_q && rdata_q.task_id > best_task_q))) begin
        best_found_d = 1'b1;
        best_idx_d   = rd_idx_q;
        best_prio_d  = rdata_q.prio;
        best_task_d  = rdata_q.task_id;
        best_user_d  = rdata_q.user_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      best_found_q  <= 1'b0;
    end else begin
      match_found_q <= match_found_d;
      free_found_q  <= free_found_d;
      best_found_q  <= best_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q  <= match_idx_d;
    match_user_q <= match_user_d;
    free_idx_q   <= free_idx_d;
    best_idx_q   <= best_idx_d;
    best_prio_q  <= best_prio_d;
    best_task_q  <= best_task_d;
    best_user_q  <= best_user_d;
  end

  // commit: table update and result
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = addr_i;
    wr_data    = '0;
    res_status = ST_OK;
    res_user   = '0;
    unique case (cmd_q)
      CMD_ADD: begin
        wr_data = '{valid: 1'b1, task_id: task_q, user_id: user_q, prio: pri_q};
        wr_addr = match_found_q ? match_idx_q : free_idx_q;
        wr_en   = match_found_q || free_found_q;
        if (!(match_found_q || free_found_q)) begin
          res_status = ST_FULL;
        end
      end
      CMD_EDIT: begin
        wr_data = '{valid: 1'b1, task_id: task_q, user_id: match_user_q, prio: pri_q};
        wr_addr = match_idx_q;
        wr_en   = match_found_q;
        if (!match_found_q) begin
          res_status = ST_MISSING;
        end
      end
      CMD_REMOVE: begin
        wr_addr = match_idx_q;
        wr_en   = match_found_q;
        if (!match_found_q) begin
          res_status = ST_MISSING;
        end
      end
      CMD_EXEC: begin
        wr_addr = best_idx_q;
        wr_en   = best_found_q;
        if (best_found_q) begin
          res_user = best_user_q;
        end else begin
          res_status = ST_MISSING;
        end
      end
    endcase
    wr_en = wr_en && ctrl_i.commit;
    if (ctrl_i.clr_we) begin
      wr_en   = 1'b1;
      wr_addr = addr_i;
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      status_q   <= res_status;
      user_out_q <= res_user;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign user_id_out_o   = user_out_q;

endmodule

[rtl/pta_ctrl.sv]
// sequencer: clearing pass, table scan, commit and result hand-off
`timescale 1ns / 1ps
module pta_ctrl import pta_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output ctrl_t         ctrl_o,
  output logic [AW-1:0] addr_o,
  input  stat_t         stat_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_DONE
  } state_e;

  localparam logic [AW-1:0] LastAddr = AW'(CAPACITY - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          ready_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && ready_q) begin
          ctrl_o.cmd_load = 1'b1;
          cnt_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ctrl_o.rd_en = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = S_DRAIN;
        end
      end
      // last read data is folded into the accumulators here
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        ctrl_o.commit = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctrl_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;
  assign addr_o     = cnt_q;

endmodule

[sim/pta_result_checker.sv]
// request/result checker for the priority task table: predicts every result and compares
`timescale 1ns / 1ps
module pta_result_checker import pta_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] user_id_i,
  input  logic [15:0] task_id_i,
  input  logic [31:0] priority_req_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] user_id_out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned exec_ok_o,
  output int unsigned full_o,
  output int unsigned missing_o
);

  typedef struct packed {
    status_e     status;
    logic [15:0] user;
  } task_result_t;

  logic        slot_valid [CAPACITY];
  logic [15:0] slot_task  [CAPACITY];
  logic [15:0] slot_user  [CAPACITY];
  logic [31:0] slot_prio  [CAPACITY];

  task_result_t pending_results [$];
  task_result_t oldest;
  task_result_t predicted;
  int unsigned  fail_count;
  int unsigned  results_seen;
  int unsigned  exec_ok_seen;
  int unsigned  full_seen;
  int unsigned  missing_seen;

  function automatic int find_task(logic [15:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit < 0 && slot_valid[i] && slot_task[i] == id) hit = i;
    end
    return hit;
  endfunction

  // applies one request to the table copy and returns the result it should produce
  function automatic task_result_t run_table_cmd(cmd_e op, logic [15:0] user,
                                                 logic [15:0] id, logic [31:0] prio);
    task_result_t res;
    int           slot;
    res.status = ST_OK;
    res.user   = '0;
    slot       = find_task(id);
    case (op)
      CMD_ADD: begin
        // a new id takes the lowest free slot
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot < 0 && !slot_valid[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          slot_valid[slot] = 1'b1;
          slot_task[slot]  = id;
          slot_user[slot]  = user;
          slot_prio[slot]  = prio;
        end
      end
      CMD_EDIT: begin
        if (slot < 0) res.status = ST_MISSING;
        else slot_prio[slot] = prio;
      end
      CMD_REMOVE: begin
        if (slot < 0) res.status = ST_MISSING;
        else slot_valid[slot] = 1'b0;
      end
      default: begin
        slot = -1;
        // ties on priority go to the higher task id
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_valid[i] && (slot < 0 || slot_prio[i] > slot_prio[slot] ||
              (slot_prio[i] == slot_prio[slot] && slot_task[i] > slot_task[slot])))
            slot = i;
        end
        if (slot < 0) begin
          res.status = ST_MISSING;
        end else begin
          res.user         = slot_user[slot];
          slot_valid[slot] = 1'b0;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: result %0d %s: got %0h, expected %0h", $time, results_seen, what, got,
             want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) slot_valid[i] = 1'b0;
      pending_results.delete();
      fail_count   = 0;
      results_seen = 0;
      exec_ok_seen = 0;
      full_seen    = 0;
      missing_seen = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("arrived with no request pending", {14'd0, status_i}, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (status_i !== oldest.status)
            report_mismatch("status", {14'd0, status_i}, {14'd0, oldest.status});
          if (user_id_out_i !== oldest.user)
            report_mismatch("user id", user_id_out_i, oldest.user);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        predicted = run_table_cmd(cmd_e'(cmd_i), user_id_i, task_id_i, priority_req_i);
        pending_results.push_back(predicted);
        if (predicted.status == ST_FULL) full_seen++;
        if (predicted.status == ST_MISSING) missing_seen++;
        if (predicted.status == ST_OK && cmd_e'(cmd_i) == CMD_EXEC) exec_ok_seen++;
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= pending_results.size();
    results_o    <= results_seen;
    exec_ok_o    <= exec_ok_seen;
    full_o       <= full_seen;
    missing_o    <= missing_seen;
  end

endmodule

[sim/tb_top.sv]
// testbench top for the priority task table: stimulus, result sink, watchdog and verdict
`timescale 1ns / 1ps
module tb_top;
  import pta_pkg::*;

  localparam int unsigned CAPACITY   = CAPACITY_DEF;
  localparam int unsigned RAND_ITEMS = 400;
  localparam int unsigned ID_POOL    = 72;
  localparam int unsigned HOLD_LEN   = 600;
  localparam int unsigned IDLE_LIMIT = 5000;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  cmd_i;
  logic [15:0] user_id_i;
  logic [15:0] task_id_i;
  logic [31:0] priority_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] user_id_out_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned exec_ok;
  int unsigned full_cnt;
  int unsigned missing_cnt;
  int unsigned sent;
  bit          send_burst;
  int unsigned idle_cycles;

  priority_task_table #(.CAPACITY(CAPACITY)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .user_id_i, .task_id_i,
    .priority_req_i, .out_valid_o, .out_ready_i, .status_o, .user_id_out_o
  );

  pta_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .user_id_i, .task_id_i, .priority_req_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .user_id_out_i(user_id_out_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_o(results),
    .exec_ok_o(exec_ok), .full_o(full_cnt), .missing_o(missing_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  // called at a clock edge; returns at the edge where the request is taken
  task automatic send_req(cmd_e op, logic [15:0] user, logic [15:0] id, logic [31:0] prio);
    int unsigned gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= op;
    user_id_i      <= user;
    task_id_i      <= id;
    priority_req_i <= prio;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // result sink with random stalls and one long hold-off
  initial begin
    int unsigned taken;
    int unsigned gap;
    bit          recv_burst;
    taken      = 0;
    recv_burst = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 25 == 0) recv_burst = ($urandom_range(0, 2) == 0);
      gap = (taken == 40) ? HOLD_LEN : draw_gap(recv_burst);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("** priority_task_table: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    phase_e      phase;
    cmd_e        op;
    logic [15:0] id_salt;
    logic [15:0] id;
    logic [15:0] user;
    logic [31:0] prio;
    int unsigned fill_next;
    int unsigned pick;
    int unsigned directed;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_ADD;
    user_id_i      = '0;
    task_id_i      = '0;
    priority_req_i = '0;
    sent           = 0;
    idle_cycles    = 0;
    send_burst     = 1'b0;
    fill_next      = 0;
    phase          = PH_FILL;
    id_salt        = 16'($urandom) & 16'hff80;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, overwrite, tie break, slot reuse
    send_req(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
    send_req(CMD_EDIT,   16'h0000, 16'h0005, 32'h1);
    send_req(CMD_REMOVE, 16'h0000, 16'h0005, 32'h0);
    send_req(CMD_ADD,    16'h0000, 16'h0000, 32'h0);
    send_req(CMD_ADD,    16'hffff, 16'hffff, 32'hffff_ffff);
    send_req(CMD_ADD,    16'habcd, 16'h1234, 32'hffff_ffff);
    send_req(CMD_ADD,    16'h5555, 16'h0000, 32'h7);
    send_req(CMD_EDIT,   16'h0000, 16'h1234, 32'h0);
    send_req(CMD_EDIT,   16'hffff, 16'h1234, 32'hffff_ffff);
    send_req(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
    send_req(CMD_EXEC,   16'hffff, 16'hffff, 32'hffff_ffff);
    send_req(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
    send_req(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
    send_req(CMD_ADD,    16'h0001, 16'h0010, 32'd100);
    send_req(CMD_ADD,    16'h0002, 16'h0020, 32'd100);
    send_req(CMD_ADD,    16'h0003, 16'h0030, 32'd50);
    send_req(CMD_REMOVE, 16'h0000, 16'h0020, 32'h0);
    send_req(CMD_REMOVE, 16'h0000, 16'h0020, 32'h0);
    send_req(CMD_EDIT,   16'h0000, 16'h0030, 32'd200);
    send_req(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
    send_req(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
    send_req(CMD_EXEC,   16'h0000, 16'h0000, 32'h0);
    directed = sent;

    // random: fill the table past capacity, drain it, refill, then mix
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case (n / 100)
          0, 2:    phase = PH_FILL;
          1:       phase = PH_DRAIN;
          default: phase = PH_MIXED;
        endcase
      end
      if (n % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  op = pick < 80 ? CMD_ADD : pick < 88 ? CMD_EDIT :
                       pick < 93 ? CMD_REMOVE : CMD_EXEC;
        PH_DRAIN: op = pick < 15 ? CMD_ADD : pick < 30 ? CMD_EDIT :
                       pick < 55 ? CMD_REMOVE : CMD_EXEC;
        default:  op = cmd_e'(pick / 25);
      endcase
      if (op == CMD_ADD && phase == PH_FILL && $urandom_range(0, 4) != 0) begin
        // walk the id pool so the table really runs full
        id        = id_salt | 16'(fill_next);
        fill_next = (fill_next + 1) % ID_POOL;
      end else if ($urandom_range(0, 9) == 0) begin
        id = 16'($urandom);
      end else begin
        id = id_salt | 16'($urandom_range(0, ID_POOL - 1));
      end
      user = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 5) prio = $urandom_range(0, 7);
      else if (pick == 5) prio = '0;
      else if (pick == 6) prio = '1;
      else prio = $urandom;
      send_req(op, user, id, prio);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("covered %0d requests (%0d directed), %0d results compared", sent, directed,
             results);
    $display("results: %0d executed tasks, %0d table-full drops, %0d not found", exec_ok,
             full_cnt, missing_cnt);
    if (fail_count + pending == 0) begin
      $display("** priority_task_table: PASSED **");
    end else begin
      $display("** priority_task_table: FAILED **");
    end
    $finish;
  end

endmodule
